@@ rtl/core/can_signal_field_codec_core_assert.svh @@
// assertion macros shared by the rtl that checks itself
`ifndef CAN_SIGNAL_FIELD_CODEC_CORE_ASSERT_SVH
`define CAN_SIGNAL_FIELD_CODEC_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is applied
`define CSFC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is applied
`define CSFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/csfc_pkg.sv @@
package csfc_pkg;

  localparam int unsigned FRAME_BYTES    = 64;
  localparam int unsigned MAX_FIELD_BITS = 32;
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned SEL_W          = $clog2(FIELD_W);
  localparam int unsigned ADDR_W         = $clog2(FRAME_BYTES);
  // byte index plus walk offset, with room for a borrow in motorola order
  localparam int unsigned IDX_W          = 7;
  // a field of FIELD_W bits at any bit offset spans this many bytes at most
  localparam int unsigned WIN_BYTES      = (FIELD_W + 7 + 7) / 8;
  localparam int unsigned WIN_W          = WIN_BYTES * 8;
  localparam int unsigned CNT_W          = $clog2(WIN_BYTES + 1);

  typedef enum logic [1:0] {
    OP_WR_BYTE = 2'd0,
    OP_RD_BYTE = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_INSERT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_e;

  typedef logic [WIN_BYTES-1:0][7:0] win_t;

  typedef struct packed {
    logic [5:0]         first;
    logic               moto;
    logic [2:0]         off;
    logic [CNT_W-1:0]   nbytes;
    logic               write;
    logic               sext;
    logic [5:0]         len;
    logic [FIELD_W-1:0] fmask;
    win_t               wval;
    win_t               wmask;
  } cmd_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wr_data;
  } mem_req_t;

endpackage

@@ rtl/core/csfc_payload_ram.sv @@
module csfc_payload_ram import csfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]             mem_q [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] vld_q;
  logic [7:0]             rd_data_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : 8'h00;

endmodule

@@ rtl/core/csfc_field_prep.sv @@
module csfc_field_prep import csfc_pkg::*; (
  input  logic [1:0]         op_i,
  input  logic [5:0]         byte_index_i,
  input  logic [7:0]         byte_value_i,
  input  logic [8:0]         start_bit_i,
  input  logic [5:0]         bit_length_i,
  input  logic               big_endian_i,
  input  logic               is_signed_i,
  input  logic [FIELD_W-1:0] field_value_i,
  output cmd_t               cmd_o
);

  logic [5:0]         len_c;
  logic [FIELD_W-1:0] fmask;
  logic [FIELD_W-1:0] hmask;
  logic [FIELD_W-1:0] smask;
  logic               sfits;
  logic [FIELD_W-1:0] sat_s;
  logic [FIELD_W-1:0] sat_u;
  logic [FIELD_W-1:0] sat;
  logic [2:0]         off;
  logic [5:0]         span;
  logic [CNT_W-1:0]   nb_sig;
  logic [WIN_W-1:0]   wval_flat;
  logic [WIN_W-1:0]   wmask_flat;

  assign len_c = (bit_length_i > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : bit_length_i;
  assign fmask = (len_c >= 6'(FIELD_W)) ? '1 : ((FIELD_W'(1) << len_c) - FIELD_W'(1));

  // signed range check: bits from the field's sign bit upward must all agree
  assign hmask = fmask >> 1;
  assign smask = ~hmask;
  assign sfits = field_value_i[FIELD_W-1] ? ((field_value_i & smask) == smask)
                                          : ((field_value_i & smask) == '0);
  assign sat_s = sfits ? (field_value_i & fmask)
                       : (field_value_i[FIELD_W-1] ? (fmask & ~hmask) : hmask);
  assign sat_u = (|(field_value_i & ~fmask)) ? fmask : field_value_i;
  assign sat   = is_signed_i ? sat_s : sat_u;

  assign off    = start_bit_i[2:0];
  assign span   = 6'(off) + len_c - 6'd1;
  assign nb_sig = (len_c == 6'd0) ? '0 : (CNT_W'(span[5:3]) + CNT_W'(1));

  assign wval_flat  = {{(WIN_W-FIELD_W){1'b0}}, sat} << off;
  assign wmask_flat = {{(WIN_W-FIELD_W){1'b0}}, fmask} << off;

  always_comb begin
    cmd_o.first  = start_bit_i[8:3];
    cmd_o.moto   = big_endian_i;
    cmd_o.off    = off;
    cmd_o.nbytes = nb_sig;
    cmd_o.write  = 1'b0;
    cmd_o.sext   = is_signed_i;
    cmd_o.len    = len_c;
    cmd_o.fmask  = fmask;
    cmd_o.wval   = win_t'(wval_flat);
    cmd_o.wmask  = win_t'(wmask_flat);
    case (op_e'(op_i))
      OP_WR_BYTE: begin
        cmd_o.first  = byte_index_i;
        cmd_o.moto   = 1'b0;
        cmd_o.off    = 3'd0;
        cmd_o.nbytes = CNT_W'(1);
        cmd_o.write  = 1'b1;
        cmd_o.sext   = 1'b0;
        cmd_o.len    = 6'd8;
        cmd_o.fmask  = '0;
        cmd_o.wval   = win_t'({{(WIN_W-8){1'b0}}, byte_value_i});
        cmd_o.wmask  = win_t'({{(WIN_W-8){1'b0}}, 8'hFF});
      end
      OP_RD_BYTE: begin
        cmd_o.first  = byte_index_i;
        cmd_o.moto   = 1'b0;
        cmd_o.off    = 3'd0;
        cmd_o.nbytes = CNT_W'(1);
        cmd_o.sext   = 1'b0;
        cmd_o.len    = 6'd8;
        cmd_o.fmask  = FIELD_W'(8'hFF);
      end
      OP_INSERT: begin
        cmd_o.write = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/can_signal_field_codec_core.sv @@
// sequencing: after the accepting edge the sequencer walks the N payload bytes the
// request touches (1 for byte requests, 1 to 5 for signals, 0 for a zero-length
// signal), each with a read in ST_READ and, on writes, a write-back in ST_MODIFY, then
// strobes the result in ST_DONE; a new request is taken in the cycle of the strobe;
// the receiver cannot stall; reset clears the sequencer and marks all payload bytes
// as zero at once, so requests are taken right after reset
`include "can_signal_field_codec_core_assert.svh"

module can_signal_field_codec_core import csfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic [5:0]         byte_index_i,
  input  logic [7:0]         byte_value_i,
  input  logic [8:0]         start_bit_i,
  input  logic [5:0]         bit_length_i,
  input  logic               big_endian_i,
  input  logic               is_signed_i,
  input  logic [FIELD_W-1:0] field_value_i,
  output logic               done_o,
  output logic [FIELD_W-1:0] read_value_o,
  output logic               out_of_range_o
);

  state_e             state_q, state_d;
  cmd_t               cmd_d, cmd_q;
  logic [CNT_W-1:0]   k_q;
  win_t               win_q;
  logic               oor_q;
  logic               in_q;
  logic               accept;
  logic [IDX_W-1:0]   idx;
  logic               in_store;
  logic               last;
  mem_req_t           mem_req;
  logic [7:0]         rd_data;
  logic [WIN_W-1:0]   win_flat;
  logic [FIELD_W-1:0] field;
  logic [5:0]         lm1;
  logic               neg;

  csfc_field_prep u_prep (
    .op_i          (op_i),
    .byte_index_i  (byte_index_i),
    .byte_value_i  (byte_value_i),
    .start_bit_i   (start_bit_i),
    .bit_length_i  (bit_length_i),
    .big_endian_i  (big_endian_i),
    .is_signed_i   (is_signed_i),
    .field_value_i (field_value_i),
    .cmd_o         (cmd_d)
  );

  csfc_payload_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  assign accept = start_i && !busy_o;

  // motorola order walks bytes downward; a borrow lands above the store
  assign idx = cmd_q.moto ? (IDX_W'(cmd_q.first) - IDX_W'(k_q))
                          : (IDX_W'(cmd_q.first) + IDX_W'(k_q));
  assign in_store = idx < IDX_W'(FRAME_BYTES);
  assign last     = (k_q == (cmd_q.nbytes - CNT_W'(1)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          state_d = (cmd_d.nbytes == '0) ? ST_DONE : ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ:   state_d = ST_MODIFY;
      ST_MODIFY: state_d = last ? ST_DONE : ST_READ;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o          = 1'b1;
    done_o          = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.addr    = idx[ADDR_W-1:0];
    mem_req.wr_data = (rd_data & ~cmd_q.wmask[k_q]) | (cmd_q.wval[k_q] & cmd_q.wmask[k_q]);
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
      end
      ST_READ: begin
        mem_req.rd_en = in_store;
      end
      ST_MODIFY: begin
        mem_req.wr_en = cmd_q.write && in_q;
      end
      ST_DONE: begin
        busy_o = 1'b0;
        done_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      oor_q   <= 1'b0;
      in_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        k_q   <= '0;
        oor_q <= 1'b0;
      end else if (state_q == ST_READ) begin
        in_q  <= in_store;
        oor_q <= oor_q | !in_store;
      end else if (state_q == ST_MODIFY) begin
        k_q <= k_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
      win_q <= '0;
    end else if (state_q == ST_MODIFY) begin
      win_q[k_q] <= in_q ? rd_data : 8'h00;
    end
  end

  // align the gathered bytes, mask to the length and sign-extend
  assign win_flat = win_q;
  assign field    = FIELD_W'(win_flat >> cmd_q.off) & cmd_q.fmask;
  assign lm1      = cmd_q.len - 6'd1;
  assign neg      = cmd_q.sext && (cmd_q.len != 6'd0) && field[lm1[SEL_W-1:0]];

  assign read_value_o   = cmd_q.write ? '0 : (neg ? (field | ~cmd_q.fmask) : field);
  assign out_of_range_o = oor_q;

  `CSFC_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE, "accepted request left sequencer idle")
  `CSFC_ASSERT_IMPLY(a_write_in_store, mem_req.wr_en, in_store && (state_q == ST_MODIFY) && cmd_q.write, "payload write outside store or phase")
  `CSFC_ASSERT_IMPLY(a_walk_bounded, (state_q == ST_READ) || (state_q == ST_MODIFY), k_q < cmd_q.nbytes, "byte walk ran past the field span")
  `CSFC_ASSERT_NEXT(a_done_single, done_o && !accept, !done_o, "result strobe held longer than one cycle")

endmodule

@@ tb/sv/can_signal_field_codec_core_tb.sv @@
`timescale 1ns / 100ps

module can_signal_field_codec_core_tb;
  import csfc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_PRINTED = 100;

  typedef struct {
    op_e          op;
    logic [5:0]   byte_index;
    logic [7:0]   byte_value;
    logic [8:0]   start_bit;
    logic [5:0]   bit_length;
    logic         big_endian;
    logic         is_signed;
    logic [31:0]  field_value;
  } codec_req_t;

  typedef struct {
    logic [FIELD_W-1:0] read_value;
    logic               out_of_range;
  } codec_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         op_i;
  logic [5:0]         byte_index_i;
  logic [7:0]         byte_value_i;
  logic [8:0]         start_bit_i;
  logic [5:0]         bit_length_i;
  logic               big_endian_i;
  logic               is_signed_i;
  logic [FIELD_W-1:0] field_value_i;
  logic               done_o;
  logic [FIELD_W-1:0] read_value_o;
  logic               out_of_range_o;

  logic [7:0]    payload_model [FRAME_BYTES];
  codec_result_t pending_results[$];
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;

  can_signal_field_codec_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .byte_index_i   (byte_index_i),
    .byte_value_i   (byte_value_i),
    .start_bit_i    (start_bit_i),
    .bit_length_i   (bit_length_i),
    .big_endian_i   (big_endian_i),
    .is_signed_i    (is_signed_i),
    .field_value_i  (field_value_i),
    .done_o         (done_o),
    .read_value_o   (read_value_o),
    .out_of_range_o (out_of_range_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // expected result of one request, updates the payload copy on writes
  function automatic codec_result_t apply_codec_request(input codec_req_t rq);
    codec_result_t     res;
    int unsigned       len;
    int                first_byte;
    int                cur_byte;
    int                byte_idx;
    int unsigned       bit_pos;
    longint unsigned   ones;
    longint unsigned   acc;
    longint unsigned   ins_val;
    longint            sval;
    longint            hi;
    longint            lo;
    res.out_of_range = 1'b0;
    len = (32'(rq.bit_length) > MAX_FIELD_BITS) ? MAX_FIELD_BITS : 32'(rq.bit_length);
    ones = (64'd1 << len) - 64'd1;
    acc = '0;
    ins_val = '0;
    case (rq.op)
      OP_WR_BYTE: begin
        if (32'(rq.byte_index) < FRAME_BYTES) payload_model[rq.byte_index] = rq.byte_value;
        else res.out_of_range = 1'b1;
      end
      OP_RD_BYTE: begin
        if (32'(rq.byte_index) < FRAME_BYTES) acc = 64'(payload_model[rq.byte_index]);
        else res.out_of_range = 1'b1;
      end
      default: begin
        if (rq.op == OP_INSERT && len > 0) begin
          if (rq.is_signed) begin
            sval = longint'($signed(rq.field_value));
            hi = (longint'(1) << (len - 1)) - 1;
            lo = -hi - 1;
            if (sval > hi) sval = hi;
            if (sval < lo) sval = lo;
            ins_val = longint'(sval) & ones;
          end else begin
            ins_val = (64'(rq.field_value) > ones) ? ones : 64'(rq.field_value);
          end
        end
        first_byte = int'(rq.start_bit >> 3);
        for (int unsigned i = 0; i < len; i++) begin
          bit_pos = 32'(rq.start_bit) + i;
          cur_byte = int'(bit_pos >> 3);
          // motorola walks bytes downward from the first byte
          byte_idx = rq.big_endian ? (2 * first_byte - cur_byte) : cur_byte;
          if (byte_idx >= 0 && byte_idx < int'(FRAME_BYTES)) begin
            if (rq.op == OP_EXTRACT) acc[i] = payload_model[byte_idx][bit_pos % 8];
            else payload_model[byte_idx][bit_pos % 8] = ins_val[i];
          end else begin
            res.out_of_range = 1'b1;
          end
        end
        if (rq.op == OP_EXTRACT && rq.is_signed && len > 0 && acc[len-1]) acc |= ~ones;
      end
    endcase
    res.read_value = acc[FIELD_W-1:0];
    return res;
  endfunction

  function automatic codec_req_t mk_req(input op_e op, input logic [5:0] byte_index,
                                        input logic [7:0] byte_value,
                                        input logic [8:0] start_bit,
                                        input logic [5:0] bit_length,
                                        input logic big_endian, input logic is_signed,
                                        input logic [31:0] field_value);
    codec_req_t rq;
    rq.op = op;
    rq.byte_index = byte_index;
    rq.byte_value = byte_value;
    rq.start_bit = start_bit;
    rq.bit_length = bit_length;
    rq.big_endian = big_endian;
    rq.is_signed = is_signed;
    rq.field_value = field_value;
    return rq;
  endfunction

  // values near the saturation bounds of the field, or plain random ones
  function automatic logic [31:0] random_field_value(input logic [5:0] bit_length);
    int unsigned     len;
    longint unsigned half;
    longint unsigned v;
    len = (32'(bit_length) > MAX_FIELD_BITS) ? MAX_FIELD_BITS : 32'(bit_length);
    if (len == 0) len = 1;
    half = 64'd1 << (len - 1);
    case ($urandom_range(0, 3))
      0: v = 64'($urandom_range(0, 255));
      1: v = -longint'($urandom_range(1, 256));
      2: v = 64'($urandom());
      default: begin
        case ($urandom_range(0, 5))
          0: v = (half << 1) - 1;
          1: v = half << 1;
          2: v = half - 1;
          3: v = half;
          4: v = -half;
          default: v = -half - 1;
        endcase
      end
    endcase
    return v[31:0];
  endfunction

  function automatic codec_req_t random_request();
    codec_req_t  rq;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) rq.op = OP_WR_BYTE;
    else if (r < 35) rq.op = OP_RD_BYTE;
    else if (r < 65) rq.op = OP_EXTRACT;
    else rq.op = OP_INSERT;
    rq.byte_index = 6'($urandom_range(0, 63));
    rq.byte_value = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 5) rq.bit_length = 6'd0;
    else if (r < 10) rq.bit_length = 6'($urandom_range(33, 63));
    else if (r < 20) begin
      case ($urandom_range(0, 4))
        0: rq.bit_length = 6'd1;
        1: rq.bit_length = 6'd8;
        2: rq.bit_length = 6'd16;
        3: rq.bit_length = 6'd31;
        default: rq.bit_length = 6'd32;
      endcase
    end else rq.bit_length = 6'($urandom_range(1, 32));
    // keep a good share of signals in the first bytes so they overlap
    if ($urandom_range(0, 99) < 30) rq.start_bit = 9'($urandom_range(0, 63));
    else rq.start_bit = 9'($urandom_range(0, 511));
    rq.big_endian = 1'($urandom_range(0, 1));
    rq.is_signed = 1'($urandom_range(0, 1));
    rq.field_value = random_field_value(rq.bit_length);
    return rq;
  endfunction

  task automatic send_request(input codec_req_t rq);
    start_i <= 1'b1;
    op_i <= rq.op;
    byte_index_i <= rq.byte_index;
    byte_value_i <= rq.byte_value;
    start_bit_i <= rq.start_bit;
    bit_length_i <= rq.bit_length;
    big_endian_i <= rq.big_endian;
    is_signed_i <= rq.is_signed;
    field_value_i <= rq.field_value;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(apply_codec_request(rq));
  endtask

  // start low with junk on the request fields
  task automatic idle_cycles(input int unsigned n);
    codec_req_t junk;
    junk = random_request();
    start_i <= 1'b0;
    op_i <= junk.op;
    byte_index_i <= junk.byte_index;
    byte_value_i <= junk.byte_value;
    start_bit_i <= junk.start_bit;
    bit_length_i <= junk.bit_length;
    big_endian_i <= junk.big_endian;
    is_signed_i <= junk.is_signed;
    field_value_i <= junk.field_value;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_results_drained();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    codec_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no request pending");
      end else begin
        exp_res = pending_results.pop_front();
        if (read_value_o !== exp_res.read_value)
          report_mismatch($sformatf("read_value got %h want %h",
                                    read_value_o, exp_res.read_value));
        if (out_of_range_o !== exp_res.out_of_range)
          report_mismatch($sformatf("out_of_range got %b want %b",
                                    out_of_range_o, exp_res.out_of_range));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("can_signal_field_codec_core_tb failed");
    $finish;
  end

  task automatic test_byte_access();
    send_request(mk_req(OP_WR_BYTE, 6'd0, 8'hA5, 9'd0, 6'd0, 1'b0, 1'b0, 32'd0));
    send_request(mk_req(OP_WR_BYTE, 6'd63, 8'hFF, 9'd0, 6'd0, 1'b0, 1'b0, 32'd0));
    send_request(mk_req(OP_WR_BYTE, 6'd10, 8'h00, 9'd0, 6'd0, 1'b0, 1'b0, 32'd0));
    send_request(mk_req(OP_RD_BYTE, 6'd0, 8'h00, 9'd0, 6'd0, 1'b0, 1'b0, 32'd0));
    send_request(mk_req(OP_RD_BYTE, 6'd63, 8'h00, 9'd0, 6'd0, 1'b0, 1'b0, 32'd0));
    send_request(mk_req(OP_RD_BYTE, 6'd10, 8'h00, 9'd0, 6'd0, 1'b0, 1'b0, 32'd0));
  endtask

  task automatic test_signal_extract();
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd0, 6'd8, 1'b0, 1'b1, 32'd0));
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd504, 6'd8, 1'b0, 1'b0, 32'd0));
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd507, 6'd32, 1'b1, 1'b1, 32'd0));
    // runs past the end of the store
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd500, 6'd32, 1'b0, 1'b0, 32'd0));
    // motorola index goes negative
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd3, 6'd16, 1'b1, 1'b0, 32'd0));
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd0, 6'd0, 1'b0, 1'b1, 32'd0));
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd0, 6'd63, 1'b0, 1'b1, 32'd0));
  endtask

  task automatic test_signal_insert();
    send_request(mk_req(OP_INSERT, 6'd0, 8'd0, 9'd20, 6'd4, 1'b0, 1'b0, 32'd100));
    send_request(mk_req(OP_INSERT, 6'd0, 8'd0, 9'd32, 6'd8, 1'b0, 1'b1, -32'sd1000));
    send_request(mk_req(OP_INSERT, 6'd0, 8'd0, 9'd40, 6'd8, 1'b0, 1'b1, 32'd1000));
    send_request(mk_req(OP_INSERT, 6'd0, 8'd0, 9'd64, 6'd32, 1'b0, 1'b1, 32'h8000_0000));
    send_request(mk_req(OP_INSERT, 6'd0, 8'd0, 9'd128, 6'd32, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_request(mk_req(OP_INSERT, 6'd0, 8'd0, 9'd200, 6'd0, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_request(mk_req(OP_INSERT, 6'd0, 8'd0, 9'd2, 6'd20, 1'b1, 1'b0, 32'h000F_FFFF));
    send_request(mk_req(OP_INSERT, 6'd0, 8'd0, 9'd505, 6'd16, 1'b0, 1'b0, 32'h0000_ABCD));
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd20, 6'd4, 1'b0, 1'b0, 32'd0));
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd32, 6'd16, 1'b0, 1'b1, 32'd0));
    send_request(mk_req(OP_EXTRACT, 6'd0, 8'd0, 9'd64, 6'd40, 1'b0, 1'b1, 32'd0));
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit with_gaps);
    for (int unsigned n = 0; n < count; n++) begin
      send_request(random_request());
      if (with_gaps && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 19));
    end
  endtask

  task automatic test_drain_pause();
    for (int unsigned k = 0; k < 4; k++) begin
      test_random_traffic($urandom_range(5, 20), 1'b0);
      wait_results_drained();
    end
  endtask

  initial begin
    mismatch_count = 0;
    for (int i = 0; i < FRAME_BYTES; i++) payload_model[i] = 8'h00;
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = OP_WR_BYTE;
    byte_index_i = '0;
    byte_value_i = '0;
    start_bit_i = '0;
    bit_length_i = '0;
    big_endian_i = 1'b0;
    is_signed_i = 1'b0;
    field_value_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_byte_access();
    test_signal_extract();
    test_signal_insert();
    test_random_traffic(1300, 1'b1);
    test_drain_pause();
    test_random_traffic(500, 1'b0);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("can_signal_field_codec_core_tb passed");
    end else begin
      $display("can_signal_field_codec_core_tb failed");
    end
    $finish;
  end

endmodule
